/* rtl/u2u_pkg.sv */
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types, constants and lookup functions for the UTF-8 to UTF-16
// stream decoder: byte classes, DFA states, result kinds and the result item.
// ----------------------------------------------------------------------------
package u2u_pkg;

   localparam int DEF_OFFSET_WIDTH = 32;
   localparam int BYTE_W           = 8;
   localparam int ACC_W            = 21;
   localparam int UNIT_W           = 16;
   localparam int OUT_OFF_W        = 32;
   localparam int MAX_RESULTS      = 3;
   localparam int RES_CNT_W        = 2;
   localparam int FIFO_DEPTH       = 4;

   localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD7C0;
   localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

   typedef enum logic [1:0] {
      KIND_UNIT           = 2'd0,
      KIND_END_OK         = 2'd1,
      KIND_END_INCOMPLETE = 2'd2,
      KIND_REJECT         = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      DFA_ACCEPT = 4'd0,
      DFA_REJECT = 4'd1,
      DFA_NEED1  = 4'd2,   // one continuation byte left
      DFA_NEED2  = 4'd3,   // two continuation bytes left
      DFA_AFT_E0 = 4'd4,
      DFA_AFT_ED = 4'd5,
      DFA_AFT_F0 = 4'd6,
      DFA_AFT_F1 = 4'd7,   // after F1..F3
      DFA_AFT_F4 = 4'd8
   } dfa_type;

   typedef enum logic [3:0] {
      CLS_ASCII   = 4'd0,
      CLS_CONT_80 = 4'd1,
      CLS_LEAD2   = 4'd2,
      CLS_LEAD3   = 4'd3,
      CLS_ED      = 4'd4,
      CLS_F4      = 4'd5,
      CLS_LEAD4   = 4'd6,
      CLS_CONT_A0 = 4'd7,
      CLS_INVALID = 4'd8,
      CLS_CONT_90 = 4'd9,
      CLS_E0      = 4'd10,
      CLS_F0      = 4'd11
   } cls_type;

   typedef struct packed {
      logic [UNIT_W-1:0]    code_unit;
      kind_type             kind;
      logic [OUT_OFF_W-1:0] resume;
      logic [OUT_OFF_W-1:0] units;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      dfa_type              dfa;
      logic [ACC_W-1:0]     acc;
      logic                 stop;
      logic                 rearm;
      logic [RES_CNT_W-1:0] n_results;
   } step_ctl_type;

   function automatic cls_type byte_class(logic [BYTE_W-1:0] b);
      cls_type c;
      priority if (b < 8'h80) c = CLS_ASCII;
      else if (b < 8'h90)     c = CLS_CONT_80;
      else if (b < 8'hA0)     c = CLS_CONT_90;
      else if (b < 8'hC0)     c = CLS_CONT_A0;
      else if (b < 8'hC2)     c = CLS_INVALID;
      else if (b < 8'hE0)     c = CLS_LEAD2;
      else if (b == 8'hE0)    c = CLS_E0;
      else if (b == 8'hED)    c = CLS_ED;
      else if (b < 8'hF0)     c = CLS_LEAD3;
      else if (b == 8'hF0)    c = CLS_F0;
      else if (b < 8'hF4)     c = CLS_LEAD4;
      else if (b == 8'hF4)    c = CLS_F4;
      else                    c = CLS_INVALID;
      return c;
   endfunction

   function automatic dfa_type dfa_next(dfa_type st, cls_type cls);
      logic    cont_any;
      dfa_type n;
      cont_any = (cls == CLS_CONT_80) || (cls == CLS_CONT_90) || (cls == CLS_CONT_A0);
      n = DFA_REJECT;
      unique case (st)
         DFA_ACCEPT: begin
            unique case (cls)
               CLS_ASCII: n = DFA_ACCEPT;
               CLS_LEAD2: n = DFA_NEED1;
               CLS_LEAD3: n = DFA_NEED2;
               CLS_ED:    n = DFA_AFT_ED;
               CLS_F4:    n = DFA_AFT_F4;
               CLS_LEAD4: n = DFA_AFT_F1;
               CLS_E0:    n = DFA_AFT_E0;
               CLS_F0:    n = DFA_AFT_F0;
               default:   n = DFA_REJECT;
            endcase
         end
         DFA_NEED1:  n = cont_any ? DFA_ACCEPT : DFA_REJECT;
         DFA_NEED2:  n = cont_any ? DFA_NEED1 : DFA_REJECT;
         DFA_AFT_E0: n = (cls == CLS_CONT_A0) ? DFA_NEED1 : DFA_REJECT;
         DFA_AFT_ED: n = (cls == CLS_CONT_80 || cls == CLS_CONT_90) ? DFA_NEED1 : DFA_REJECT;
         DFA_AFT_F0: n = (cls == CLS_CONT_90 || cls == CLS_CONT_A0) ? DFA_NEED2 : DFA_REJECT;
         DFA_AFT_F1: n = cont_any ? DFA_NEED2 : DFA_REJECT;
         DFA_AFT_F4: n = (cls == CLS_CONT_80) ? DFA_NEED2 : DFA_REJECT;
         default:    n = DFA_REJECT;
      endcase
      return n;
   endfunction

endpackage

/* rtl/u2u_req_if.sv */
// ----------------------------------------------------------------------------
// u2u_req_if
// Source byte channel: valid/ready handshake with one UTF-8 byte and a
// last-of-buffer flag per transaction.
// ----------------------------------------------------------------------------
interface u2u_req_if;
   logic                        valid;
   logic                        ready;
   logic [u2u_pkg::BYTE_W-1:0]  data_byte;
   logic                        is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

/* rtl/u2u_rsp_if.sv */
// ----------------------------------------------------------------------------
// u2u_rsp_if
// Result channel: valid/ready handshake carrying one UTF-16 code unit or an
// end/reject status per transaction.
// ----------------------------------------------------------------------------
interface u2u_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [u2u_pkg::UNIT_W-1:0]     code_unit;
   logic [1:0]                     result_kind;
   logic [u2u_pkg::OUT_OFF_W-1:0]  resume_offset;
   logic [u2u_pkg::OUT_OFF_W-1:0]  units_written;
   logic                           last_of_run;

   modport source (output valid, output code_unit, output result_kind,
                   output resume_offset, output units_written, output last_of_run,
                   input ready);
   modport sink   (input valid, input code_unit, input result_kind,
                   input resume_offset, input units_written, input last_of_run,
                   output ready);
endinterface

/* rtl/u2u_step.sv */
// ----------------------------------------------------------------------------
// u2u_step
// One DFA step: classifies the byte, advances state and accumulator, and
// builds up to three result items (code units, surrogate pair, end status).
// ----------------------------------------------------------------------------
module u2u_step #(
   parameter int OFFSET_WIDTH = u2u_pkg::DEF_OFFSET_WIDTH
) (
   input  u2u_pkg::dfa_type                                   dfa,
   input  logic [u2u_pkg::ACC_W-1:0]                          acc,
   input  logic [OFFSET_WIDTH-1:0]                            src_cnt,
   input  logic [OFFSET_WIDTH-1:0]                            unit_cnt,
   input  logic [u2u_pkg::BYTE_W-1:0]                         data_byte,
   input  logic                                               is_last,
   output u2u_pkg::step_ctl_type                              ctl,
   output logic [OFFSET_WIDTH-1:0]                            src_cnt_next,
   output logic [OFFSET_WIDTH-1:0]                            unit_cnt_next,
   output u2u_pkg::rsp_item_type [u2u_pkg::MAX_RESULTS-1:0]   results
);
   import u2u_pkg::*;

   cls_type              cls;
   logic [ACC_W-1:0]     acc_nx;
   dfa_type              dfa_nx;
   logic                 is_pair;
   logic                 done;
   logic [1:0]           emitted;
   logic [UNIT_W-1:0]    unit0;
   logic [UNIT_W-1:0]    unit1;
   rsp_item_type         end_item;
   rsp_item_type         unit_item0;
   rsp_item_type         unit_item1;
   logic [RES_CNT_W-1:0] n_res;

   always_comb begin
      cls = byte_class(data_byte);
      if (dfa != DFA_ACCEPT) begin
         acc_nx = {acc[ACC_W-7:0], data_byte[5:0]};
      end else begin
         acc_nx = ACC_W'((8'hFF >> cls) & data_byte);
      end
      dfa_nx       = dfa_next(dfa, cls);
      src_cnt_next = src_cnt + OFFSET_WIDTH'(1);

      done    = (dfa_nx == DFA_ACCEPT);
      is_pair = (acc_nx[ACC_W-1:UNIT_W] != '0);
      emitted = done ? (is_pair ? 2'd2 : 2'd1) : 2'd0;
      unit_cnt_next = unit_cnt + OFFSET_WIDTH'(emitted);

      // surrogate pair: high = D7C0 + cp[20:10], low = DC00 + cp[9:0]
      unit0 = is_pair ? HI_SURR_BASE + UNIT_W'(acc_nx[ACC_W-1:10]) : acc_nx[UNIT_W-1:0];
      unit1 = LO_SURR_BASE + UNIT_W'(acc_nx[9:0]);

      unit_item0           = '0;
      unit_item0.kind      = KIND_UNIT;
      unit_item0.code_unit = unit0;
      unit_item1           = '0;
      unit_item1.kind      = KIND_UNIT;
      unit_item1.code_unit = unit1;

      end_item       = '0;
      end_item.kind  = done ? KIND_END_OK : KIND_END_INCOMPLETE;
      end_item.resume = done ? OUT_OFF_W'(src_cnt_next) : OUT_OFF_W'(src_cnt);
      end_item.units = OUT_OFF_W'(unit_cnt_next);

      ctl     = '0;
      ctl.dfa = dfa_nx;
      ctl.acc = acc_nx;

      if (dfa_nx == DFA_REJECT) begin
         results[0]        = '0;
         results[0].kind   = KIND_REJECT;
         results[0].resume = OUT_OFF_W'(src_cnt);
         results[0].units  = OUT_OFF_W'(unit_cnt);
         results[1]        = '0;
         results[2]        = '0;
         n_res             = RES_CNT_W'(1);
         ctl.rearm         = is_last;
         ctl.stop          = !is_last;
      end else begin
         results[0] = done ? unit_item0 : end_item;
         results[1] = is_pair ? unit_item1 : end_item;
         results[2] = end_item;
         n_res      = RES_CNT_W'(emitted) + RES_CNT_W'(is_last);
         ctl.rearm  = is_last;
      end
      ctl.n_results = n_res;

      for (int i = 0; i < MAX_RESULTS; i++) begin
         results[i].last = (RES_CNT_W'(i + 1) == n_res);
      end
   end

endmodule

/* rtl/u2u_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// u2u_rsp_fifo
// Small result queue: takes up to three items per cycle from the step logic
// and hands them out one per transaction on the result channel.
// ----------------------------------------------------------------------------
module u2u_rsp_fifo (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic [u2u_pkg::RES_CNT_W-1:0]                      push_cnt,
   input  u2u_pkg::rsp_item_type [u2u_pkg::MAX_RESULTS-1:0]   push_items,
   output logic                                               room_ok,
   u2u_rsp_if.source                                          rsp_bus
);
   import u2u_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rsp_item_type     mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   rsp_item_type     head;

   always_comb begin
      pop       = (count_ff != '0) && rsp_bus.ready;
      // room for a full burst once this cycle's pop is counted
      room_ok   = count_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS) + CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
      head      = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (RES_CNT_W'(i) < push_cnt) begin
            mem_ff[PTR_W'(wr_ptr_ff + PTR_W'(i))] <= push_items[i];
         end
      end
   end

   assign rsp_bus.valid         = (count_ff != '0);
   assign rsp_bus.code_unit     = head.code_unit;
   assign rsp_bus.result_kind   = head.kind;
   assign rsp_bus.resume_offset = head.resume;
   assign rsp_bus.units_written = head.units;
   assign rsp_bus.last_of_run   = head.last;

endmodule

/* rtl/utf8_to_utf16_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_unit
// UTF-8 to UTF-16 stream decoder: validating DFA per byte, code point
// accumulation, surrogate pairs, end and reject reporting.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then decoded and
//   written into the result queue once it has room; results leave from there.
// Throughput: one byte per cycle while the queue has room; the 4-entry result
//   queue drains one result per cycle while the channel is ready, and a byte
//   waits for three free slots, counting a slot read out in the same cycle.
// Reset: synchronous; DFA to accept, counts to zero, start offset to zero.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_unit #(
   parameter int OFFSET_WIDTH = u2u_pkg::DEF_OFFSET_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   u2u_req_if.sink                           req_bus,
   u2u_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [u2u_pkg::OUT_OFF_W-1:0]     csr_wdata
);
   import u2u_pkg::*;

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]       in_byte_ff;
   logic                    in_last_ff;

   // decoder state
   dfa_type                 dfa_ff, dfa_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    stopped_ff, stopped_in;
   logic                    run_active_ff, run_active_in;
   logic [OFFSET_WIDTH-1:0] src_cnt_ff, src_cnt_in;
   logic [OFFSET_WIDTH-1:0] unit_cnt_ff, unit_cnt_in;
   logic [OUT_OFF_W-1:0]    start_ff;

   step_ctl_type                        ctl;
   logic [OFFSET_WIDTH-1:0]             src_cnt_step;
   logic [OFFSET_WIDTH-1:0]             unit_cnt_step;
   rsp_item_type [MAX_RESULTS-1:0]      results;
   logic                                room_ok;
   logic                                proc;
   logic                                rearm;
   logic [RES_CNT_W-1:0]                push_cnt;

   u2u_step #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_step (
      .dfa           (dfa_ff),
      .acc           (acc_ff),
      .src_cnt       (src_cnt_ff),
      .unit_cnt      (unit_cnt_ff),
      .data_byte     (in_byte_ff),
      .is_last       (in_last_ff),
      .ctl           (ctl),
      .src_cnt_next  (src_cnt_step),
      .unit_cnt_next (unit_cnt_step),
      .results       (results)
   );

   u2u_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_items (results),
      .room_ok    (room_ok),
      .rsp_bus    (rsp_bus)
   );

   always_comb begin
      proc          = in_valid_ff && room_ok;
      req_bus.ready = !in_valid_ff || proc;
      in_valid_in   = req_bus.valid || (in_valid_ff && !proc);

      // bytes after a reject are dropped; the last one re-arms
      push_cnt = (proc && !stopped_ff) ? ctl.n_results : '0;
      rearm    = proc && (stopped_ff ? in_last_ff : ctl.rearm);

      dfa_in        = dfa_ff;
      acc_in        = acc_ff;
      stopped_in    = stopped_ff;
      run_active_in = run_active_ff;
      src_cnt_in    = src_cnt_ff;
      unit_cnt_in   = unit_cnt_ff;

      if (proc && !stopped_ff) begin
         dfa_in        = ctl.dfa;
         acc_in        = ctl.acc;
         stopped_in    = ctl.stop;
         run_active_in = 1'b1;
         src_cnt_in    = src_cnt_step;
         unit_cnt_in   = unit_cnt_step;
      end
      if (rearm) begin
         dfa_in        = DFA_ACCEPT;
         acc_in        = '0;
         stopped_in    = 1'b0;
         run_active_in = 1'b0;
         src_cnt_in    = '0;
         unit_cnt_in   = OFFSET_WIDTH'(start_ff);
      end
      if (csr_we && !run_active_ff) begin
         unit_cnt_in = OFFSET_WIDTH'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         dfa_ff        <= DFA_ACCEPT;
         acc_ff        <= '0;
         stopped_ff    <= 1'b0;
         run_active_ff <= 1'b0;
         src_cnt_ff    <= '0;
         unit_cnt_ff   <= '0;
         start_ff      <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         dfa_ff        <= dfa_in;
         acc_ff        <= acc_in;
         stopped_ff    <= stopped_in;
         run_active_ff <= run_active_in;
         src_cnt_ff    <= src_cnt_in;
         unit_cnt_ff   <= unit_cnt_in;
         if (csr_we) begin
            start_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.is_last;
      end
   end

endmodule
